// ===== sv/tsa_pkg.sv =====
// Shared types, widths and constants of the triangle solid angle block.
// Used by tsa_isqrt, tsa_cordic and triangle_solid_angle; depends on nothing.
`default_nettype none

package tsa_pkg;

    // Opcodes carried in the input tuser field
    typedef enum logic [1:0] {
        OP_VERTEX   = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_QUERY    = 2'd2
    } op_t;

    localparam int FIELD_ADDR_W = 10;    // slot and corner field width
    localparam int TRI_W        = 3 * FIELD_ADDR_W;
    localparam int ALIGN_LOG    = 19;    // aligned magnitudes stay below 2^19
    localparam int AL_W         = ALIGN_LOG + 1;
    localparam int SQ_W         = 2 * AL_W;          // sum of three squares
    localparam int ROOT_W       = SQ_W / 2;
    localparam int PROD_W       = 2 * AL_W;
    localparam int CR_W         = PROD_W + 1;        // cross product term
    localparam int DOT_W        = PROD_W + 2;        // dot product
    localparam int DP_W         = AL_W + CR_W;       // corner times cross term
    localparam int TERM_W       = DOT_W + ROOT_W + 1;
    localparam int WIDE_W       = 64;
    localparam int ISQRT_STAGES = ROOT_W / 2;        // two root bits per stage
    localparam int NORM_W       = 30;                // CORDIC operand magnitude
    localparam int NORM_TOP     = NORM_W - 1;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 35;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
    localparam int CORDIC_LAT   = 3 + CORDIC_STAGES;
    localparam int ANGLE_W      = 32;

    localparam logic signed [CZ_W-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [CZ_W-1:0] ANGLE_MAX = 35'sd1686629713;

    // atan(2^-i) in Q.30, truncated
    localparam logic signed [CZ_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
        35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
        35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
        35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
        35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
        35'sd1023,      35'sd511,       35'sd255,       35'sd127,
        35'sd63,        35'sd31,        35'sd15,        35'sd7,
        35'sd3,         35'sd1
    };

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } sqrt_state_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } cordic_state_t;

    // One restoring square root iteration
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st,
                                              input logic [SQ_W-1:0] bitv);
        sqrt_state_t nx;
        logic [SQ_W:0] trial;
        trial = {1'b0, st.res} + {1'b0, bitv};
        nx.rem = st.rem;
        nx.res = st.res >> 1;
        if ({1'b0, st.rem} >= trial) begin
            nx.rem = st.rem - SQ_W'(trial);
            nx.res = (st.res >> 1) + bitv;
        end
        return nx;
    endfunction

    // One vectoring CORDIC rotation
    function automatic cordic_state_t cordic_step(input cordic_state_t st,
                                                  input int unsigned i);
        cordic_state_t nx;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        xs = st.x >>> i;
        ys = st.y >>> i;
        nx = st;
        if (st.y[CX_W-1]) begin
            nx.x = st.x - ys;
            nx.y = st.y + xs;
            nx.z = st.z - ATAN_TAB[i];
        end else if (st.y != '0) begin
            nx.x = st.x + ys;
            nx.y = st.y - xs;
            nx.z = st.z + ATAN_TAB[i];
        end
        return nx;
    endfunction

endpackage

`default_nettype wire

// ===== sv/triangle_solid_angle.sv =====
// Top level of the triangle solid angle block: vertex and triangle stores,
// alignment, determinant and denominator, then atan2 by CORDIC.
// Depends on tsa_pkg, tsa_ram, tsa_isqrt and tsa_cordic.
//
// Usage:
//   The slave channel carries one item per transfer; s_tuser is the opcode.
//   Vertex and triangle writes update the stores at their transfer and give
//   no result; a query gives one result on the master channel, the solid
//   angle in m_tdata (Q3.28) and the saturation flag in m_tuser.
//   A query's result passes through 40 register stages: store reads,
//   alignment, products, a 10-stage square root, the denominator, an
//   18-stage CORDIC and the output register.
//   Throughput: one item per cycle while not stalled; results in query order.
//   Writes take effect for every later query, also one in the next cycle.
//   Reset clears all valid bits and m_tvalid; the stores hold no defined
//   contents until written.
//   When the receiver stalls with a result waiting, the whole pipeline and
//   s_tready hold; nothing is lost or repeated.
`default_nettype none

module triangle_solid_angle #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 1024,
    parameter int COORD_BITS    = 24,
    localparam int TDATA_W = ((4 * tsa_pkg::FIELD_ADDR_W + 3 * COORD_BITS + 7) / 8) * 8
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    // s_tdata: slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  wire  [TDATA_W-1:0]        s_tdata,
    // s_tuser: op
    input  wire  [1:0]                s_tuser,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    // m_tdata: solid_angle
    output logic [tsa_pkg::ANGLE_W-1:0] m_tdata,
    // m_tuser: saturated
    output logic                      m_tuser,
    output logic                      m_tvalid,
    input  wire                       m_tready
);
    localparam int CB      = COORD_BITS;
    localparam int FA      = tsa_pkg::FIELD_ADDR_W;
    localparam int VA_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TA_W    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int S_MAX   = (CB > tsa_pkg::ALIGN_LOG) ? CB - tsa_pkg::ALIGN_LOG : 0;
    localparam int S_W     = (S_MAX > 0) ? $clog2(S_MAX + 1) : 1;
    localparam int AL      = tsa_pkg::AL_W;
    localparam int LEN_R   = 8 + tsa_pkg::ISQRT_STAGES;     // lengths ready
    localparam int DEN_R   = LEN_R + 3;                     // denominator ready
    localparam int LAST    = DEN_R + tsa_pkg::CORDIC_LAT;   // angle ready
    localparam int DOT_DLY = LEN_R - 8;
    localparam int DET_DLY = DEN_R - 10;

    // Input fields
    logic [FA-1:0] slot;
    logic [CB-1:0] coord [3];
    logic [FA-1:0] corner_in [3];

    assign slot = s_tdata[FA-1:0];
    for (genvar j = 0; j < 3; j++) begin : g_fields
        assign coord[j]     = s_tdata[FA + j*CB +: CB];
        assign corner_in[j] = s_tdata[FA + 3*CB + j*FA +: FA];
    end

    // Handshake: advance the whole pipeline when the output register frees
    logic adv, acc;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;

    // Decode the opcode
    logic vtx_we, tri_we, query_acc;
    always_comb begin
        vtx_we    = 1'b0;
        tri_we    = 1'b0;
        query_acc = 1'b0;
        unique case (s_tuser)
            tsa_pkg::OP_VERTEX:   vtx_we    = acc && (32'(slot) < MAX_VERTICES);
            tsa_pkg::OP_TRIANGLE: tri_we    = acc && (32'(slot) < MAX_TRIANGLES);
            tsa_pkg::OP_QUERY:    query_acc = acc;
            default: ;
        endcase
    end

    // Valid and saturation lines travel with the data
    logic [LAST:1] vld_reg;
    logic [LAST:6] sat_reg;
    logic          lost;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAST-1:1], query_acc};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sat_reg <= {sat_reg[LAST-1:6], lost};
        end
    end

    // Triangle table, read at the query's transfer
    logic [tsa_pkg::TRI_W-1:0] tri_rdata;

    tsa_ram #(.WIDTH(tsa_pkg::TRI_W), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
        .aclk  (aclk),
        .we    (tri_we),
        .waddr (TA_W'(slot)),
        .wdata ({corner_in[2], corner_in[1], corner_in[0]}),
        .re    (adv),
        .raddr (TA_W'(slot)),
        .rdata (tri_rdata)
    );

    // Stage 1: hold query point and slot range
    logic [CB-1:0] q1_reg [3];
    logic          slot_ok1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_reg       <= coord;
            slot_ok1_reg <= 32'(slot) < MAX_TRIANGLES;
        end
    end

    // Vertex store, one copy per corner
    logic [FA-1:0]     corner1 [3];
    logic [3*CB-1:0]   vtx_rdata [3];

    for (genvar k = 0; k < 3; k++) begin : g_vtx
        assign corner1[k] = slot_ok1_reg ? tri_rdata[k*FA +: FA] : '0;
        tsa_ram #(.WIDTH(3 * CB), .DEPTH(MAX_VERTICES)) u_vtx_ram (
            .aclk  (aclk),
            .we    (vtx_we),
            .waddr (VA_W'(slot)),
            .wdata ({coord[2], coord[1], coord[0]}),
            .re    (adv),
            .raddr (VA_W'(corner1[k])),
            .rdata (vtx_rdata[k])
        );
    end

    // Stage 2: corner range flags
    logic [CB-1:0] q2_reg [3];
    logic [2:0]    cok2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q2_reg <= q1_reg;
            for (int k = 0; k < 3; k++) begin
                cok2_reg[k] <= 32'(corner1[k]) < MAX_VERTICES;
            end
        end
    end

    // Stage 3: corners relative to the query point
    logic signed [CB:0] d3_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    d3_reg[k][j] <= (cok2_reg[k]
                        ? $signed({vtx_rdata[k][j*CB + CB - 1], vtx_rdata[k][j*CB +: CB]})
                        : $signed((CB + 1)'(0)))
                        - $signed({q2_reg[j][CB-1], q2_reg[j]});
                end
            end
        end
    end

    // Stage 4: magnitudes, signs and their OR
    logic [CB-1:0] mag4_reg [3][3];
    logic [CB-1:0] mag_next [3][3];
    logic          neg4_reg [3][3];
    logic [CB-1:0] or4_reg;
    logic [CB-1:0] or_next;

    always_comb begin
        or_next = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                mag_next[k][j] = d3_reg[k][j][CB] ? CB'(-d3_reg[k][j]) : CB'(d3_reg[k][j]);
                or_next        = or_next | mag_next[k][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            or4_reg <= or_next;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    mag4_reg[k][j] <= mag_next[k][j];
                    neg4_reg[k][j] <= d3_reg[k][j][CB];
                end
            end
        end
    end

    // Stage 5: common alignment shift
    logic [CB-1:0]  mag5_reg [3][3];
    logic           neg5_reg [3][3];
    logic [S_W-1:0] sh5_reg;
    logic [S_W-1:0] sh_next;

    always_comb begin
        sh_next = '0;
        for (int i = tsa_pkg::ALIGN_LOG; i < CB; i++) begin
            if (or4_reg[i]) begin
                sh_next = S_W'(i - tsa_pkg::ALIGN_LOG + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
            sh5_reg  <= sh_next;
        end
    end

    // Stage 6: align, flag dropped bits
    logic signed [AL-1:0] c6_reg [3][3];
    logic signed [AL-1:0] c_next [3][3];
    logic [AL-2:0]        am;

    always_comb begin
        lost = 1'b0;
        am   = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                am   = (AL - 1)'(mag5_reg[k][j] >> sh5_reg);
                lost = lost | (|(mag5_reg[k][j] & ~({CB{1'b1}} << sh5_reg)));
                c_next[k][j] = neg5_reg[k][j] ? -$signed({1'b0, am}) : $signed({1'b0, am});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c6_reg <= c_next;
        end
    end

    // Stage 7: squares, cross-product and dot-product terms
    logic signed [tsa_pkg::PROD_W-1:0] sq7_reg  [3][3];
    logic signed [tsa_pkg::PROD_W-1:0] cp7_reg  [6];
    logic signed [tsa_pkg::PROD_W-1:0] dp7_reg  [3][3];
    logic signed [AL-1:0]              a7_reg   [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    sq7_reg[k][j] <= c6_reg[k][j] * c6_reg[k][j];
                end
            end
            cp7_reg[0] <= c6_reg[1][1] * c6_reg[2][2];
            cp7_reg[1] <= c6_reg[1][2] * c6_reg[2][1];
            cp7_reg[2] <= c6_reg[1][0] * c6_reg[2][2];
            cp7_reg[3] <= c6_reg[1][2] * c6_reg[2][0];
            cp7_reg[4] <= c6_reg[1][0] * c6_reg[2][1];
            cp7_reg[5] <= c6_reg[1][1] * c6_reg[2][0];
            for (int j = 0; j < 3; j++) begin
                dp7_reg[0][j] <= c6_reg[0][j] * c6_reg[1][j];
                dp7_reg[1][j] <= c6_reg[1][j] * c6_reg[2][j];
                dp7_reg[2][j] <= c6_reg[2][j] * c6_reg[0][j];
            end
            a7_reg <= c6_reg[0];
        end
    end

    // Stage 8: sums of squares, cross product, dot products
    logic [tsa_pkg::SQ_W-1:0]         ss8_reg  [3];
    logic signed [tsa_pkg::CR_W-1:0]  cr8_reg  [3];
    logic signed [tsa_pkg::DOT_W-1:0] dot8_reg [3];
    logic signed [AL-1:0]             a8_reg   [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                ss8_reg[k] <= tsa_pkg::SQ_W'(sq7_reg[k][0]) + tsa_pkg::SQ_W'(sq7_reg[k][1])
                            + tsa_pkg::SQ_W'(sq7_reg[k][2]);
                dot8_reg[k] <= tsa_pkg::DOT_W'(dp7_reg[k][0]) + tsa_pkg::DOT_W'(dp7_reg[k][1])
                             + tsa_pkg::DOT_W'(dp7_reg[k][2]);
                cr8_reg[k]  <= tsa_pkg::CR_W'(cp7_reg[2*k]) - tsa_pkg::CR_W'(cp7_reg[2*k+1]);
            end
            a8_reg <= a7_reg;
        end
    end

    // Corner lengths
    logic [tsa_pkg::ROOT_W-1:0] len18 [3];

    for (genvar k = 0; k < 3; k++) begin : g_len
        tsa_isqrt u_isqrt (
            .aclk   (aclk),
            .en     (adv),
            .rad_i  (ss8_reg[k]),
            .root_o (len18[k])
        );
    end

    // Stages 9 and 10: determinant
    logic signed [tsa_pkg::DP_W-1:0]   dp9_reg [3];
    logic signed [tsa_pkg::WIDE_W-1:0] det10_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                dp9_reg[j] <= a8_reg[j] * cr8_reg[j];
            end
            det10_reg <= tsa_pkg::WIDE_W'(dp9_reg[0]) - tsa_pkg::WIDE_W'(dp9_reg[1])
                       + tsa_pkg::WIDE_W'(dp9_reg[2]);
        end
    end

    // Delay lines up to the length and denominator stages
    logic signed [tsa_pkg::DOT_W-1:0]  dot_dly_reg [DOT_DLY][3];
    logic signed [tsa_pkg::WIDE_W-1:0] det_dly_reg [DET_DLY];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dot_dly_reg[0] <= dot8_reg;
            for (int i = 1; i < DOT_DLY; i++) begin
                dot_dly_reg[i] <= dot_dly_reg[i-1];
            end
            det_dly_reg[0] <= det10_reg;
            for (int i = 1; i < DET_DLY; i++) begin
                det_dly_reg[i] <= det_dly_reg[i-1];
            end
        end
    end

    // Stages 19 to 21: denominator abc + (a.b)c + (b.c)a + (c.a)b
    logic [2*tsa_pkg::ROOT_W-1:0]      pab19_reg;
    logic [tsa_pkg::ROOT_W-1:0]        lc19_reg;
    logic signed [tsa_pkg::TERM_W-1:0] t19_reg [3];
    logic [3*tsa_pkg::ROOT_W-1:0]      p20_reg;
    logic signed [tsa_pkg::WIDE_W-1:0] s20_reg, tb20_reg;
    logic signed [tsa_pkg::WIDE_W-1:0] den21_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pab19_reg  <= len18[0] * len18[1];
            lc19_reg   <= len18[2];
            t19_reg[0] <= dot_dly_reg[DOT_DLY-1][0] * $signed({1'b0, len18[2]});
            t19_reg[1] <= dot_dly_reg[DOT_DLY-1][1] * $signed({1'b0, len18[0]});
            t19_reg[2] <= dot_dly_reg[DOT_DLY-1][2] * $signed({1'b0, len18[1]});
            p20_reg    <= pab19_reg * lc19_reg;
            s20_reg    <= tsa_pkg::WIDE_W'(t19_reg[0]) + tsa_pkg::WIDE_W'(t19_reg[1]);
            tb20_reg   <= tsa_pkg::WIDE_W'(t19_reg[2]);
            den21_reg  <= $signed(tsa_pkg::WIDE_W'(p20_reg)) + s20_reg + tb20_reg;
        end
    end

    // atan2(det, denom)
    logic signed [tsa_pkg::CZ_W-1:0] z_last;

    tsa_cordic u_cordic (
        .aclk (aclk),
        .en   (adv),
        .y_i  (det_dly_reg[DET_DLY-1]),
        .x_i  (den21_reg),
        .z_o  (z_last)
    );

    // Output register: halve, clamp, present
    logic signed [tsa_pkg::CZ_W-1:0]    half;
    logic [tsa_pkg::ANGLE_W-1:0]        angle_reg, angle_next;
    logic                               osat_reg, osat_next;

    always_comb begin
        half       = z_last >>> 1;
        angle_next = tsa_pkg::ANGLE_W'(half);
        osat_next  = sat_reg[LAST];
        if (half > tsa_pkg::ANGLE_MAX) begin
            angle_next = tsa_pkg::ANGLE_W'(tsa_pkg::ANGLE_MAX);
            osat_next  = 1'b1;
        end else if (half < -tsa_pkg::ANGLE_MAX) begin
            angle_next = tsa_pkg::ANGLE_W'(-tsa_pkg::ANGLE_MAX);
            osat_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            angle_reg <= angle_next;
            osat_reg  <= osat_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = angle_reg;
    assign m_tuser  = osat_reg;

endmodule

`default_nettype wire

// ===== sv/tsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module tsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                   aclk,
    input  wire                   we,
    input  wire  [AW-1:0]         waddr,
    input  wire  [WIDTH-1:0]      wdata,
    input  wire                   re,
    input  wire  [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and read-before-write read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/tsa_isqrt.sv =====
// Pipelined floor square root, two root bits per register stage.
// Depends on tsa_pkg.
`default_nettype none

module tsa_isqrt (
    input  wire                          aclk,
    input  wire                          en,
    input  wire  [tsa_pkg::SQ_W-1:0]     rad_i,
    output logic [tsa_pkg::ROOT_W-1:0]   root_o
);
    localparam int NS = tsa_pkg::ISQRT_STAGES;
    localparam int SW = tsa_pkg::SQ_W;

    tsa_pkg::sqrt_state_t st_reg  [NS];
    tsa_pkg::sqrt_state_t st_next [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        tsa_pkg::sqrt_state_t st_in;
        tsa_pkg::sqrt_state_t st_mid;

        // Take the radicand at the first stage, the previous stage elsewhere
        if (g == 0) begin : g_first
            assign st_in = '{rem: rad_i, res: '0};
        end else begin : g_rest
            assign st_in = st_reg[g-1];
        end

        always_comb begin
            st_mid     = tsa_pkg::sqrt_step(st_in, SW'(1) << (SW - 2 - 4 * g));
            st_next[g] = tsa_pkg::sqrt_step(st_mid, SW'(1) << (SW - 4 - 4 * g));
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    assign root_o = st_reg[NS-1].res[tsa_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/tsa_cordic.sv =====
// Pipelined atan2 in Q.30: operand normalization, quadrant fold and a
// vectoring CORDIC with two rotations per stage. Depends on tsa_pkg.
`default_nettype none

module tsa_cordic (
    input  wire                                  aclk,
    input  wire                                  en,
    input  wire  signed [tsa_pkg::WIDE_W-1:0]    y_i,
    input  wire  signed [tsa_pkg::WIDE_W-1:0]    x_i,
    output logic signed [tsa_pkg::CZ_W-1:0]      z_o
);
    localparam int WW = tsa_pkg::WIDE_W;
    localparam int NB = WW / 8;
    localparam int PW = $clog2(WW);
    localparam int NS = tsa_pkg::CORDIC_STAGES;
    localparam int CX = tsa_pkg::CX_W;

    // Stage 1: magnitudes and per-byte leading one
    logic [WW-1:0] my1_reg, mx1_reg;
    logic          ny1_reg, nx1_reg;
    logic [NB-1:0] nz1_reg;
    logic [2:0]    hi1_reg [NB];
    logic [WW-1:0] orv;
    logic [NB-1:0] nz_next;
    logic [2:0]    hi_next [NB];

    always_comb begin
        orv = (y_i[WW-1] ? WW'(-y_i) : WW'(y_i)) | (x_i[WW-1] ? WW'(-x_i) : WW'(x_i));
        for (int b = 0; b < NB; b++) begin
            nz_next[b] = |orv[8*b +: 8];
            hi_next[b] = '0;
            for (int i = 0; i < 8; i++) begin
                if (orv[8*b + i]) begin
                    hi_next[b] = 3'(i);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            my1_reg <= y_i[WW-1] ? WW'(-y_i) : WW'(y_i);
            mx1_reg <= x_i[WW-1] ? WW'(-x_i) : WW'(x_i);
            ny1_reg <= y_i[WW-1];
            nx1_reg <= x_i[WW-1];
            nz1_reg <= nz_next;
            for (int b = 0; b < NB; b++) begin
                hi1_reg[b] <= hi_next[b];
            end
        end
    end

    // Stage 2: position of the leading one of the larger magnitude
    logic [WW-1:0] my2_reg, mx2_reg;
    logic          ny2_reg, nx2_reg;
    logic [PW-1:0] pos2_reg;
    logic [PW-1:0] pos_next;

    always_comb begin
        pos_next = '0;
        for (int b = 0; b < NB; b++) begin
            if (nz1_reg[b]) begin
                pos_next = PW'(8 * b) + PW'(hi1_reg[b]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            my2_reg  <= my1_reg;
            mx2_reg  <= mx1_reg;
            ny2_reg  <= ny1_reg;
            nx2_reg  <= nx1_reg;
            pos2_reg <= pos_next;
        end
    end

    // Stage 3: normalize so the larger lies in [2^29, 2^30), fold left half
    tsa_pkg::cordic_state_t st_reg  [NS+1];
    tsa_pkg::cordic_state_t st_next [NS+1];
    logic [tsa_pkg::NORM_W-1:0] ys, xs;
    logic signed [CX-1:0]       ysg;
    logic                       xneg;

    always_comb begin
        if (pos2_reg >= PW'(tsa_pkg::NORM_TOP)) begin
            ys = tsa_pkg::NORM_W'(my2_reg >> (pos2_reg - PW'(tsa_pkg::NORM_TOP)));
            xs = tsa_pkg::NORM_W'(mx2_reg >> (pos2_reg - PW'(tsa_pkg::NORM_TOP)));
        end else begin
            ys = tsa_pkg::NORM_W'(my2_reg << (PW'(tsa_pkg::NORM_TOP) - pos2_reg));
            xs = tsa_pkg::NORM_W'(mx2_reg << (PW'(tsa_pkg::NORM_TOP) - pos2_reg));
        end
        ysg  = ny2_reg ? -$signed(CX'(ys)) : $signed(CX'(ys));
        xneg = nx2_reg && (xs != '0);
        st_next[0].x = $signed(CX'(xs));
        st_next[0].y = xneg ? -ysg : ysg;
        if (!xneg) begin
            st_next[0].z = '0;
        end else if (ysg[CX-1]) begin
            st_next[0].z = -tsa_pkg::PI_Q30;
        end else begin
            st_next[0].z = tsa_pkg::PI_Q30;
        end
    end

    // Rotation stages, two steps each
    for (genvar g = 1; g <= NS; g++) begin : g_rot
        tsa_pkg::cordic_state_t st_mid;
        always_comb begin
            st_mid     = tsa_pkg::cordic_step(st_reg[g-1], 2 * (g - 1));
            st_next[g] = tsa_pkg::cordic_step(st_mid, 2 * (g - 1) + 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s <= NS; s++) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign z_o = st_reg[NS].z;

endmodule

`default_nettype wire
